@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mts_pkg.sv @@
// ---------------------------------------------------------------------------
// mts_pkg
// Shared constants, types and codes of the timer scheduler.
// ---------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int TICK_WIDTH = 32;
    localparam int ID_W       = 4;
    localparam int IVAL_W     = 32;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    typedef enum logic [1:0] {
        REQ_TICK    = 2'd0,
        REQ_START   = 2'd1,
        REQ_STOP    = 2'd2,
        REQ_DELIVER = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    // one timer entry in the RAM
    typedef struct packed {
        logic [TICK_WIDTH-1:0] countdown;
        logic [TICK_WIDTH-1:0] reload;
    } t_entry;

endpackage

`default_nettype wire

@@ rtl/mts_ram.sv @@
// ---------------------------------------------------------------------------
// mts_ram
// Timer entry RAM: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mts_ram
    import mts_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_entry           i_wdata,
    input  wire logic             i_re,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_entry                o_rdata
);

    t_entry r_mem [NUM_TIMERS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/multi_timer_scheduler.sv @@
// ---------------------------------------------------------------------------
// multi_timer_scheduler
// Bank of periodic and one-shot timers counted in integer ticks.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request word:
//   tick, start, stop or event delivered. Start, stop and delivery act
//   as soon as their word is taken. A tick, which can pause on output
//   stalls, has these steps: taking the word, one step per timer entry
//   through the entry RAM (read, update, write back), and one flush step
//   that releases the final result; the single RAM read port sets the scan.
//   Output channel (o_out_valid / i_out_stall) carries one word per timer
//   whose event is posted in that tick, in ascending id order, with
//   o_last_of_tick set on the final word of the tick. A tick without posts
//   emits nothing.
//   The block holds one found fire back until it knows whether another one
//   follows, so the first result moves out when the second fire is found
//   and the output is free (or in the flush at the end of the scan).
//   Receiver stall: the output register holds its word; the scan pauses
//   only when a second pending word must move out and cannot.
//   New requests are taken only between ticks; o_in_stall is high during
//   a scan and its final flush.
//   Reset: all timers unarmed, unscheduled and unposted, no word pending.
//   The RAM is not cleared: entry data is used only after a start wrote it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multi_timer_scheduler
    import mts_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_req_type,
    input  wire logic [ID_W-1:0]   i_timer_id,
    input  wire logic [IVAL_W-1:0] i_start_interval,
    input  wire logic              i_start_single_shot,
    // fire channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [ID_W-1:0]        o_fired_timer,
    output logic                   o_last_of_tick
);

    // -----------------------------------------------------------------------
    // State
    // -----------------------------------------------------------------------
    t_state r_state, n_state;

    // per-timer flags live in flops so reset clears them at once
    logic [NUM_TIMERS-1:0] r_armed;
    logic [NUM_TIMERS-1:0] r_sched;
    logic [NUM_TIMERS-1:0] r_posted;
    logic [NUM_TIMERS-1:0] r_oneshot;

    logic [IDX_W-1:0] r_proc_idx;   // entry whose RAM data is on o_rdata

    // one fire held back to learn whether it is the last of the tick
    logic             r_pend_valid;
    logic [IDX_W-1:0] r_pend_idx;

    logic             r_out_valid;
    logic [ID_W-1:0]  r_out_id;
    logic             r_out_last;

    // -----------------------------------------------------------------------
    // Request decode
    // -----------------------------------------------------------------------
    t_req             req;
    logic             in_acc;
    logic             id_ok;
    logic [IDX_W-1:0] id_idx;
    logic [TICK_WIDTH-1:0] ival;
    logic             do_tick, do_start, do_stop, do_deliver;

    assign req        = t_req'(i_req_type);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign id_ok      = (32'(i_timer_id) < NUM_TIMERS);
    assign id_idx     = IDX_W'(i_timer_id);
    assign ival       = TICK_WIDTH'(i_start_interval);

    always_comb begin
        do_tick    = 1'b0;
        do_start   = 1'b0;
        do_stop    = 1'b0;
        do_deliver = 1'b0;
        if (in_acc) begin
            case (req)
                REQ_TICK:    do_tick    = 1'b1;
                REQ_START:   do_start   = id_ok && !r_armed[id_idx];
                REQ_STOP:    do_stop    = id_ok;
                REQ_DELIVER: do_deliver = id_ok && r_posted[id_idx];
                default:     do_tick    = 1'b0;
            endcase
        end
    end

    // -----------------------------------------------------------------------
    // Entry RAM
    // -----------------------------------------------------------------------
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    t_entry           mem_wdata, mem_rdata;

    mts_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // -----------------------------------------------------------------------
    // Scan datapath: entry r_proc_idx is updated this cycle
    // -----------------------------------------------------------------------
    logic                  in_scan;
    logic                  proc_sched;
    logic [TICK_WIDTH-1:0] cd_dec;
    logic                  fire;
    logic                  emit;
    logic                  reload_nz;
    logic                  out_free;
    logic                  blocked;
    logic                  adv;
    logic                  scan_push;
    logic                  flush_push;

    assign in_scan    = (r_state == S_SCAN);
    assign proc_sched = r_sched[r_proc_idx];
    // a zero countdown saturates, so it fires like a one
    assign cd_dec     = (mem_rdata.countdown == '0) ? '0
                                                    : mem_rdata.countdown - TICK_WIDTH'(1);
    assign fire       = proc_sched && (cd_dec == '0);
    assign emit       = fire && !r_posted[r_proc_idx];
    assign reload_nz  = (mem_rdata.reload != '0);
    assign out_free   = !r_out_valid || !i_out_stall;
    // pause only if a held word must move out and the output is busy
    assign blocked    = in_scan && emit && r_pend_valid && !out_free;
    assign adv        = in_scan && !blocked;
    assign scan_push  = adv && emit && r_pend_valid;
    assign flush_push = (r_state == S_FLUSH) && r_pend_valid && out_free;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_proc_idx;
        mem_wdata = mem_rdata;
        mem_re    = 1'b0;
        mem_raddr = '0;
        if (do_start) begin
            mem_we              = 1'b1;
            mem_waddr           = id_idx;
            mem_wdata.countdown = ival;
            mem_wdata.reload    = i_start_single_shot ? '0 : ival;
        end else if (adv && proc_sched && (!fire || reload_nz)) begin
            mem_we              = 1'b1;
            mem_wdata.countdown = fire ? mem_rdata.reload : cd_dec;
        end
        if (do_tick) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
        end else if (adv && (r_proc_idx != LAST_IDX)) begin
            mem_re    = 1'b1;
            mem_raddr = r_proc_idx + IDX_W'(1);
        end
    end

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (do_tick) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (adv && (r_proc_idx == LAST_IDX)) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (!r_pend_valid || out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_idx <= '0;
        end else if (do_tick) begin
            r_proc_idx <= '0;
        end else if (adv && (r_proc_idx != LAST_IDX)) begin
            r_proc_idx <= r_proc_idx + IDX_W'(1);
        end
    end

    // -----------------------------------------------------------------------
    // Timer flags
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= '0;
            r_sched   <= '0;
            r_posted  <= '0;
            r_oneshot <= '0;
        end else begin
            if (do_start) begin
                r_armed[id_idx]   <= 1'b1;
                r_sched[id_idx]   <= 1'b1;
                r_oneshot[id_idx] <= i_start_single_shot;
            end
            if (do_stop) begin
                r_armed[id_idx]  <= 1'b0;
                r_sched[id_idx]  <= 1'b0;
                r_posted[id_idx] <= 1'b0;
            end
            if (do_deliver) begin
                r_posted[id_idx] <= 1'b0;
                if (r_oneshot[id_idx]) begin
                    r_armed[id_idx] <= 1'b0;
                    r_sched[id_idx] <= 1'b0;
                end
            end
            if (adv && emit) begin
                r_posted[r_proc_idx] <= 1'b1;
            end
            if (adv && fire && !reload_nz) begin
                r_sched[r_proc_idx] <= 1'b0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Held fire and output register
    // -----------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (adv && emit) begin
            r_pend_valid <= 1'b1;
        end else if (flush_push) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit) begin
            r_pend_idx <= r_proc_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (scan_push || flush_push) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_push || flush_push) begin
            r_out_id   <= ID_W'(r_pend_idx);
            r_out_last <= flush_push;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fired_timer  = r_out_id;
    assign o_last_of_tick = r_out_last;

    // -----------------------------------------------------------------------
    // Assertions
    // -----------------------------------------------------------------------
    `ASSERT_IMPL(a_idle_no_pend, i_clk, i_rst_n, r_state == S_IDLE, !r_pend_valid, "held fire left behind after a tick")
    `ASSERT_IMPL(a_rw_apart, i_clk, i_rst_n, mem_we && mem_re && in_scan, mem_waddr != mem_raddr, "scan read and write hit one entry")
    `ASSERT_NEXT(a_post_sets, i_clk, i_rst_n, adv && emit, r_posted[$past(r_proc_idx)], "emitted fire left no posted mark")
    `ASSERT_NEXT(a_scan_end, i_clk, i_rst_n, adv && (r_proc_idx == LAST_IDX), r_state == S_FLUSH, "scan did not end after the last entry")

endmodule

`default_nettype wire
